/* sv/joystick_to_keys_and_mouse_core_assert.svh */
// assertion macros for the joystick core rtl, included by the front
// both expect clk and rst_n in the enclosing module
`ifndef JOYSTICK_TO_KEYS_AND_MOUSE_CORE_ASSERT_SVH
`define JOYSTICK_TO_KEYS_AND_MOUSE_CORE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define JTKM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define JTKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/jtkm_pkg.sv */
package jtkm_pkg;

  // configuration register widths and reset values
  localparam int CENTER_W   = 10;
  localparam int DZ_W       = 9;
  localparam int TH_W       = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CENTER_W-1:0] CENTER_RST = 10'd512;
  localparam logic [DZ_W-1:0]     DZ_RST     = 9'd50;
  localparam logic [TH_W-1:0]     TH_RST     = 9'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TH     = 2'd2;

  // result fields
  localparam int MOVE_W = 8;
  localparam int MAX_EV = 4;

  // request queue between front and back, power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    KEY_UP    = 2'd0,
    KEY_LEFT  = 2'd1,
    KEY_DOWN  = 2'd2,
    KEY_RIGHT = 2'd3
  } key_t;

  typedef struct packed {
    ev_kind_t kind;
    key_t     code;
  } ev_t;

  // events of one sample, in emit order, last holds count minus one
  typedef struct packed {
    logic [1:0]          last;
    ev_t [MAX_EV-1:0]    ev;
  } ev_list_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [DZ_W-1:0]     dz;
    logic [TH_W-1:0]     th;
  } cfg_t;

endpackage

/* sv/jtkm_front.sv */
module jtkm_front #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  jtkm_pkg::cfg_t         cfg,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] raw_x,
  input  logic [SAMPLE_BITS-1:0] raw_y,
  input  logic                   key_mode,
  output logic                   push,
  output jtkm_pkg::ev_list_t     push_ev,
  output logic                   push_xs,
  output logic [(SAMPLE_BITS > jtkm_pkg::CENTER_W ? SAMPLE_BITS : jtkm_pkg::CENTER_W)-1:0]
                                 push_xm,
  output logic                   push_ys,
  output logic [(SAMPLE_BITS > jtkm_pkg::CENTER_W ? SAMPLE_BITS : jtkm_pkg::CENTER_W)-1:0]
                                 push_ym
);

  `include "joystick_to_keys_and_mouse_core_assert.svh"

  localparam int MAG_W = (SAMPLE_BITS > jtkm_pkg::CENTER_W) ? SAMPLE_BITS : jtkm_pkg::CENTER_W;
  localparam int OFS_W = MAG_W + 1;
  localparam int NCAND = 5;

  logic [3:0]         held_r;
  logic [3:0]         held_nxt;
  logic [MAG_W-1:0]   raw_e [2];
  logic [OFS_W-1:0]   ofs [2];
  logic [OFS_W-1:0]   ofs_neg [2];
  logic               sgn [2];
  logic [MAG_W-1:0]   mag [2];
  logic [MAG_W-1:0]   dmag [2];
  logic               go_neg [2];
  logic               go_pos [2];
  jtkm_pkg::key_t     kneg [2];
  jtkm_pkg::key_t     kpos [2];
  jtkm_pkg::ev_t      cand [NCAND];
  logic [NCAND-1:0]   cand_vld;
  logic [2:0]         n_ev;
  jtkm_pkg::ev_list_t list;

  // center offset and magnitude per axis, index 0 is y, 1 is x
  always_comb begin
    raw_e[0] = MAG_W'(raw_y);
    raw_e[1] = MAG_W'(raw_x);
    kneg[0]  = jtkm_pkg::KEY_UP;
    kpos[0]  = jtkm_pkg::KEY_DOWN;
    kneg[1]  = jtkm_pkg::KEY_LEFT;
    kpos[1]  = jtkm_pkg::KEY_RIGHT;
    for (int a = 0; a < 2; a++) begin
      ofs[a]     = {1'b0, raw_e[a]} - {1'b0, MAG_W'(cfg.center)};
      ofs_neg[a] = ~ofs[a] + OFS_W'(1);
      sgn[a]     = ofs[a][MAG_W];
      mag[a]     = sgn[a] ? ofs_neg[a][MAG_W-1:0] : ofs[a][MAG_W-1:0];
      go_neg[a]  = sgn[a] && (mag[a] > MAG_W'(cfg.th));
      go_pos[a]  = !sgn[a] && (mag[a] > MAG_W'(cfg.th));
      dmag[a]    = (mag[a] < MAG_W'(cfg.dz)) ? '0 : mag[a];
    end
  end

  // candidate events in emit order and the new held key set
  always_comb begin
    for (int c = 0; c < NCAND; c++) begin
      cand[c].kind = jtkm_pkg::EV_RELEASE;
      cand[c].code = jtkm_pkg::KEY_UP;
    end
    cand_vld = '0;
    held_nxt = held_r;
    if (key_mode) begin
      for (int a = 0; a < 2; a++) begin
        // first slot of the axis
        if (go_neg[a]) begin
          cand[2*a].kind  = jtkm_pkg::EV_PRESS;
          cand[2*a].code  = kneg[a];
          cand_vld[2*a]   = !held_r[kneg[a]];
        end else if (go_pos[a]) begin
          cand[2*a].kind  = jtkm_pkg::EV_PRESS;
          cand[2*a].code  = kpos[a];
          cand_vld[2*a]   = !held_r[kpos[a]];
        end else begin
          cand[2*a].kind  = jtkm_pkg::EV_RELEASE;
          cand[2*a].code  = kneg[a];
          cand_vld[2*a]   = held_r[kneg[a]];
        end
        // second slot of the axis
        cand[2*a+1].kind = jtkm_pkg::EV_RELEASE;
        if (go_pos[a]) begin
          cand[2*a+1].code = kneg[a];
          cand_vld[2*a+1]  = held_r[kneg[a]];
        end else begin
          cand[2*a+1].code = kpos[a];
          cand_vld[2*a+1]  = held_r[kpos[a]];
        end
        held_nxt[kneg[a]] = go_neg[a];
        held_nxt[kpos[a]] = go_pos[a];
      end
    end else begin
      cand[0].code = jtkm_pkg::KEY_UP;
      cand[1].code = jtkm_pkg::KEY_LEFT;
      cand[2].code = jtkm_pkg::KEY_DOWN;
      cand[3].code = jtkm_pkg::KEY_RIGHT;
      cand_vld[3:0] = {held_r[jtkm_pkg::KEY_RIGHT], held_r[jtkm_pkg::KEY_DOWN],
                       held_r[jtkm_pkg::KEY_LEFT], held_r[jtkm_pkg::KEY_UP]};
      cand[4].kind = jtkm_pkg::EV_MOVE;
      cand[4].code = jtkm_pkg::KEY_UP;
      cand_vld[4]  = (dmag[0] != '0) || (dmag[1] != '0);
      held_nxt     = '0;
    end
  end

  // pack valid candidates into the event list
  always_comb begin
    list = '0;
    n_ev = '0;
    for (int c = 0; c < NCAND; c++) begin
      if (cand_vld[c]) begin
        if (n_ev < 3'(jtkm_pkg::MAX_EV)) begin
          list.ev[n_ev[1:0]] = cand[c];
        end
        n_ev = n_ev + 3'd1;
      end
    end
    list.last = 2'(n_ev - 3'd1);
  end

  assign push    = accept && (n_ev != '0);
  assign push_ev = list;
  assign push_xs = sgn[1];
  assign push_xm = dmag[1];
  assign push_ys = sgn[0];
  assign push_ym = dmag[0];

  // held key set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
    end
  end

  `JTKM_ASSERT_ALWAYS(a_up_down_excl,
    !(held_r[jtkm_pkg::KEY_UP] && held_r[jtkm_pkg::KEY_DOWN]), "up and down held together")
  `JTKM_ASSERT_ALWAYS(a_left_right_excl,
    !(held_r[jtkm_pkg::KEY_LEFT] && held_r[jtkm_pkg::KEY_RIGHT]), "left and right held together")
  `JTKM_ASSERT_NEXT(a_mouse_releases, accept && !key_mode, held_r == '0,
    "keys still held after mouse sample")

endmodule

/* sv/jtkm_queue.sv */
module jtkm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         vld,
  output logic         full
);

  logic [W-1:0]                 mem_r [jtkm_pkg::Q_DEPTH];
  logic [jtkm_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [jtkm_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [jtkm_pkg::Q_CNT_W-1:0] cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (cnt_r == jtkm_pkg::Q_CNT_W'(jtkm_pkg::Q_DEPTH));
  assign vld     = (cnt_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && vld;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + jtkm_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + jtkm_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + jtkm_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - jtkm_pkg::Q_CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* sv/jtkm_back.sv */
module jtkm_back #(
  parameter int SAMPLE_BITS  = 10,
  parameter int MOVE_DIVISOR = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_vld,
  input  jtkm_pkg::ev_list_t          q_ev,
  input  logic                        q_xs,
  input  logic [(SAMPLE_BITS > jtkm_pkg::CENTER_W ? SAMPLE_BITS : jtkm_pkg::CENTER_W)-1:0]
                                      q_xm,
  input  logic                        q_ys,
  input  logic [(SAMPLE_BITS > jtkm_pkg::CENTER_W ? SAMPLE_BITS : jtkm_pkg::CENTER_W)-1:0]
                                      q_ym,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_event_kind,
  output logic [1:0]                  out_key_code,
  output logic signed [jtkm_pkg::MOVE_W-1:0] out_move_x,
  output logic signed [jtkm_pkg::MOVE_W-1:0] out_move_y,
  output logic                        out_last_event
);

  localparam int MAG_W   = (SAMPLE_BITS > jtkm_pkg::CENTER_W) ? SAMPLE_BITS : jtkm_pkg::CENTER_W;
  localparam int DIV_SH  = $clog2(MOVE_DIVISOR);
  localparam int SHIFT   = MAG_W + DIV_SH;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  // rounded-up reciprocal, exact floor quotient for any MAG_W-bit magnitude
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << SHIFT) + longint'(MOVE_DIVISOR) - 1) / longint'(MOVE_DIVISOR));

  logic [PROD_W-1:0]          prod_x;
  logic [PROD_W-1:0]          prod_y;
  logic                       cur_vld_r;
  jtkm_pkg::ev_list_t         cur_ev_r;
  logic [1:0]                 cur_idx_r;
  logic [1:0]                 cur_idx_nxt;
  logic                       cur_xs_r;
  logic                       cur_ys_r;
  logic [MAG_W-1:0]           cur_qx_r;
  logic [MAG_W-1:0]           cur_qy_r;
  logic                       out_valid_r;
  jtkm_pkg::ev_kind_t         out_kind_r;
  jtkm_pkg::key_t             out_code_r;
  logic [jtkm_pkg::MOVE_W-1:0] out_mx_r;
  logic [jtkm_pkg::MOVE_W-1:0] out_my_r;
  logic                       out_last_r;
  logic                       out_free;
  logic                       emit;
  logic                       cur_done;
  logic                       cur_load;
  jtkm_pkg::ev_t              ev_sel;
  logic [jtkm_pkg::MOVE_W-1:0] mx_lo;
  logic [jtkm_pkg::MOVE_W-1:0] my_lo;
  logic [jtkm_pkg::MOVE_W-1:0] mx_w;
  logic [jtkm_pkg::MOVE_W-1:0] my_w;

  // handshake between queue, event sequencer and output register
  assign out_free    = !out_valid_r || out_ready;
  assign emit        = cur_vld_r && out_free;
  assign cur_done    = emit && (cur_idx_r == cur_ev_r.last);
  assign cur_load    = q_vld && (!cur_vld_r || cur_done);
  assign q_pop       = cur_load;
  assign cur_idx_nxt = cur_idx_r + 2'd1;

  // divide by constant as reciprocal multiply on the queue head
  assign prod_x = PROD_W'(q_xm) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(q_ym) * PROD_W'(RECIP);

  // current event and wrapped move values
  always_comb begin
    ev_sel = cur_ev_r.ev[cur_idx_r];
    mx_lo  = cur_qx_r[jtkm_pkg::MOVE_W-1:0];
    my_lo  = cur_qy_r[jtkm_pkg::MOVE_W-1:0];
    mx_w   = cur_xs_r ? (~mx_lo + jtkm_pkg::MOVE_W'(1)) : mx_lo;
    my_w   = cur_ys_r ? (~my_lo + jtkm_pkg::MOVE_W'(1)) : my_lo;
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      cur_idx_r <= '0;
    end else if (cur_load) begin
      cur_vld_r <= 1'b1;
      cur_idx_r <= '0;
    end else if (cur_done) begin
      cur_vld_r <= 1'b0;
    end else if (emit) begin
      cur_idx_r <= cur_idx_nxt;
    end
  end

  // sequencer payload
  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_ev_r <= q_ev;
      cur_xs_r <= q_xs;
      cur_ys_r <= q_ys;
      cur_qx_r <= prod_x[SHIFT +: MAG_W];
      cur_qy_r <= prod_y[SHIFT +: MAG_W];
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= ev_sel.kind;
      out_code_r <= ev_sel.code;
      out_last_r <= (cur_idx_r == cur_ev_r.last);
      if (ev_sel.kind == jtkm_pkg::EV_MOVE) begin
        out_mx_r <= mx_w;
        out_my_r <= my_w;
      end else begin
        out_mx_r <= '0;
        out_my_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_code   = out_code_r;
  assign out_move_x     = out_mx_r;
  assign out_move_y     = out_my_r;
  assign out_last_event = out_last_r;

endmodule

/* sv/joystick_to_keys_and_mouse_core.sv */
// Joystick sample to direction keys and mouse moves. A sample is taken in the
// cycle it is offered whenever the two-entry event queue has room; the front
// decides all its events at once and updates the held keys. The back emits
// one event per cycle through its output register while out_ready allows, so
// a sample that causes n events (0 to 4) puts them out in emit order, and a
// sample that causes none is never pushed into the queue. A result passes
// through a queue entry, the sequencer registers and the output register.
// Mouse divides use one constant reciprocal multiply per axis. Registers may
// be rewritten only while the block is idle.
module joystick_to_keys_and_mouse_core #(
  parameter int SAMPLE_BITS  = 10,
  parameter int MOVE_DIVISOR = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [jtkm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jtkm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              in_raw_x,
  input  logic [SAMPLE_BITS-1:0]              in_raw_y,
  input  logic                                in_key_mode,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_kind,
  output logic [1:0]                          out_key_code,
  output logic signed [jtkm_pkg::MOVE_W-1:0]  out_move_x,
  output logic signed [jtkm_pkg::MOVE_W-1:0]  out_move_y,
  output logic                                out_last_event
);

  localparam int MAG_W = (SAMPLE_BITS > jtkm_pkg::CENTER_W) ? SAMPLE_BITS : jtkm_pkg::CENTER_W;
  localparam int Q_W   = $bits(jtkm_pkg::ev_list_t) + 2 * (MAG_W + 1);

  logic [jtkm_pkg::CENTER_W-1:0] center_r;
  logic [jtkm_pkg::DZ_W-1:0]     dz_r;
  logic [jtkm_pkg::TH_W-1:0]     th_r;
  jtkm_pkg::cfg_t                cfg;
  logic                          accept;
  logic                          push;
  jtkm_pkg::ev_list_t            push_ev;
  logic                          push_xs;
  logic [MAG_W-1:0]              push_xm;
  logic                          push_ys;
  logic [MAG_W-1:0]              push_ym;
  logic [Q_W-1:0]                q_din;
  logic [Q_W-1:0]                q_dout;
  logic                          q_vld;
  logic                          q_full;
  logic                          q_pop;
  jtkm_pkg::ev_list_t            q_ev;
  logic                          q_xs;
  logic [MAG_W-1:0]              q_xm;
  logic                          q_ys;
  logic [MAG_W-1:0]              q_ym;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= jtkm_pkg::CENTER_RST;
      dz_r     <= jtkm_pkg::DZ_RST;
      th_r     <= jtkm_pkg::TH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jtkm_pkg::CFG_CENTER: center_r <= cfg_data[jtkm_pkg::CENTER_W-1:0];
        jtkm_pkg::CFG_DZ:     dz_r     <= cfg_data[jtkm_pkg::DZ_W-1:0];
        jtkm_pkg::CFG_TH:     th_r     <= cfg_data[jtkm_pkg::TH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.center = center_r;
  assign cfg.dz     = dz_r;
  assign cfg.th     = th_r;

  // input request handshake
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  jtkm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (accept),
    .raw_x    (in_raw_x),
    .raw_y    (in_raw_y),
    .key_mode (in_key_mode),
    .push     (push),
    .push_ev  (push_ev),
    .push_xs  (push_xs),
    .push_xm  (push_xm),
    .push_ys  (push_ys),
    .push_ym  (push_ym)
  );

  // event queue between front and back
  assign q_din = {push_ev, push_xs, push_xm, push_ys, push_ym};
  assign {q_ev, q_xs, q_xm, q_ys, q_ym} = q_dout;

  jtkm_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .vld   (q_vld),
    .full  (q_full)
  );

  jtkm_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MOVE_DIVISOR (MOVE_DIVISOR)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_vld          (q_vld),
    .q_ev           (q_ev),
    .q_xs           (q_xs),
    .q_xm           (q_xm),
    .q_ys           (q_ys),
    .q_ym           (q_ym),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y),
    .out_last_event (out_last_event)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

// one expected event of a joystick sample
typedef struct packed {
  jtkm_pkg::ev_kind_t kind;
  jtkm_pkg::key_t     code;
  logic signed [7:0]  dx;
  logic signed [7:0]  dy;
  logic               last;
} hid_event_t;

// tracks held keys and settings, queues the events each sample should cause
class hid_scoreboard;
  hid_event_t  pending[$];
  logic [3:0]  held;
  logic [9:0]  center;
  logic [8:0]  dead;
  logic [8:0]  threshold;
  int          divisor;
  int          errors;

  function new(int div);
    divisor   = div;
    held      = 4'b0;
    center    = 10'd512;
    dead      = 9'd50;
    threshold = 9'd200;
    errors    = 0;
  endfunction

  // register write, masked to width, unknown index dropped
  function void set_reg(logic [1:0] idx, logic [9:0] data);
    case (idx)
      jtkm_pkg::CFG_CENTER: center    = data;
      jtkm_pkg::CFG_DZ:     dead      = data[8:0];
      jtkm_pkg::CFG_TH:     threshold = data[8:0];
      default: ;
    endcase
  endfunction

  function void add_event(jtkm_pkg::ev_kind_t k, jtkm_pkg::key_t c,
                          logic signed [7:0] dx, logic signed [7:0] dy);
    hid_event_t e;
    e.kind = k;
    e.code = c;
    e.dx   = dx;
    e.dy   = dy;
    e.last = 1'b0;
    pending.push_back(e);
  endfunction

  function void press_key(jtkm_pkg::key_t c);
    if (!held[c]) begin
      held[c] = 1'b1;
      add_event(jtkm_pkg::EV_PRESS, c, 8'sd0, 8'sd0);
    end
  endfunction

  function void lift_key(jtkm_pkg::key_t c);
    if (held[c]) begin
      held[c] = 1'b0;
      add_event(jtkm_pkg::EV_RELEASE, c, 8'sd0, 8'sd0);
    end
  endfunction

  // one axis in key mode, negative key first when pushed that way
  function void axis_keys(int v, int t, jtkm_pkg::key_t neg, jtkm_pkg::key_t pos);
    if (v < -t) begin
      press_key(neg);
      lift_key(pos);
    end else if (v > t) begin
      press_key(pos);
      lift_key(neg);
    end else begin
      lift_key(neg);
      lift_key(pos);
    end
  endfunction

  // divide truncating toward zero, keep low 8 bits
  function logic signed [7:0] scaled(int v);
    int q;
    q = v / divisor;
    return q[7:0];
  endfunction

  // accepted sample: work out its events
  function void note_sample(logic [9:0] rx, logic [9:0] ry, logic key_mode);
    int ox, oy, d, first;
    first = pending.size();
    ox = int'(rx) - int'(center);
    oy = int'(ry) - int'(center);
    d  = int'(dead);
    if (key_mode) begin
      axis_keys(oy, int'(threshold), jtkm_pkg::KEY_UP, jtkm_pkg::KEY_DOWN);
      axis_keys(ox, int'(threshold), jtkm_pkg::KEY_LEFT, jtkm_pkg::KEY_RIGHT);
    end else begin
      lift_key(jtkm_pkg::KEY_UP);
      lift_key(jtkm_pkg::KEY_LEFT);
      lift_key(jtkm_pkg::KEY_DOWN);
      lift_key(jtkm_pkg::KEY_RIGHT);
      if (ox > -d && ox < d) ox = 0;
      if (oy > -d && oy < d) oy = 0;
      if (ox != 0 || oy != 0)
        add_event(jtkm_pkg::EV_MOVE, jtkm_pkg::KEY_UP, scaled(ox), scaled(oy));
    end
    if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  // compare one accepted event with the oldest expected one
  task check_event(logic [1:0] kind, logic [1:0] code, logic [7:0] dx,
                   logic [7:0] dy, logic last);
    hid_event_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected event kind %0d code %0d", kind, code));
      return;
    end
    e = pending.pop_front();
    if (kind !== e.kind)
      report($sformatf("event_kind %0d, want %0d", kind, e.kind));
    if (code !== e.code)
      report($sformatf("key_code %0d, want %0d", code, e.code));
    if (dx !== e.dx)
      report($sformatf("move_x %0d, want %0d", $signed(dx), e.dx));
    if (dy !== e.dy)
      report($sformatf("move_y %0d, want %0d", $signed(dy), e.dy));
    if (last !== e.last)
      report($sformatf("last_event %0d, want %0d", last, e.last));
  endtask
endclass

module tb_top;

  localparam int SAMPLE_W  = 10;
  localparam int MOVE_DIV  = 6;
  localparam int LIMIT     = 200000;
  localparam int DRAIN_MAX = 5000;
  localparam int SETTLE    = 6;
  localparam logic [jtkm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [jtkm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [jtkm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [SAMPLE_W-1:0]              in_raw_x = '0;
  logic [SAMPLE_W-1:0]              in_raw_y = '0;
  logic                             in_key_mode = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [1:0]                       out_event_kind;
  logic [1:0]                       out_key_code;
  logic signed [jtkm_pkg::MOVE_W-1:0] out_move_x;
  logic signed [jtkm_pkg::MOVE_W-1:0] out_move_y;
  logic                             out_last_event;

  hid_scoreboard board;
  bit jitter_on = 1'b1;
  int hold_left = 0;
  int cycles = 0;

  joystick_to_keys_and_mouse_core #(
    .SAMPLE_BITS  (SAMPLE_W),
    .MOVE_DIVISOR (MOVE_DIV)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_raw_x       (in_raw_x),
    .in_raw_y       (in_raw_y),
    .in_key_mode    (in_key_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_code   (out_key_code),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y),
    .out_last_event (out_last_event)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check accepted events, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_event(out_event_kind, out_key_code, out_move_x, out_move_y,
                        out_last_event);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(jitter_on && $urandom_range(99) < 11);
    end
  end

  // offer one sample and wait for it to be taken
  task automatic send_sample(logic [SAMPLE_W-1:0] rx, logic [SAMPLE_W-1:0] ry,
                             logic key_mode);
    while (jitter_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_raw_x    <= rx;
    in_raw_y    <= ry;
    in_key_mode <= key_mode;
    do @(posedge clk); while (!in_ready);
    board.note_sample(rx, ry, key_mode);
  endtask

  // stop sending, let every expected event come out, then settle
  task automatic wait_quiet();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0 && n < DRAIN_MAX) begin
      @(posedge clk);
      n++;
    end
    if (board.pending.size() != 0) begin
      board.report($sformatf("%0d events never came", board.pending.size()));
      board.pending.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [jtkm_pkg::CFG_IDX_W-1:0] idx,
                           logic [jtkm_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // axis sample biased toward the interesting edges of the current settings
  function automatic logic [SAMPLE_W-1:0] pick_axis();
    int c, d, t, v;
    c = int'(board.center);
    d = int'(board.dead);
    t = int'(board.threshold);
    case ($urandom_range(9))
      0, 1: v = int'($urandom_range(1023));
      2: v = c + int'($urandom_range(2 * d)) - d;
      3: v = c + t + 1 + int'($urandom_range(200));
      4: v = c - t - 1 - int'($urandom_range(200));
      5: v = c + ($urandom_range(1) ? t : -t) + int'($urandom_range(2)) - 1;
      6: v = c + ($urandom_range(1) ? d : -d) + int'($urandom_range(2)) - 1;
      7: v = $urandom_range(1) ? 0 : 1023;
      default: v = c;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic run_random(int n);
    repeat (n) send_sample(pick_axis(), pick_axis(), $urandom_range(99) < 65);
  endtask

  initial begin
    int d;
    board = new(MOVE_DIV);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: presses, releases, four-event sample, deadzone edges
    send_sample(10'd0,    10'd0,    1'b1);
    send_sample(10'd1023, 10'd1023, 1'b1);
    send_sample(10'd512,  10'd512,  1'b1);
    send_sample(10'd312,  10'd712,  1'b1);
    send_sample(10'd311,  10'd713,  1'b1);
    send_sample(10'd561,  10'd562,  1'b0);
    send_sample(10'd462,  10'd512,  1'b0);
    send_sample(10'd512,  10'd512,  1'b0);
    send_sample(10'd0,    10'd1023, 1'b0);
    send_sample(10'd0,    10'd1023, 1'b1);
    send_sample(10'd1023, 10'd0,    1'b1);
    send_sample(10'd512,  10'd0,    1'b0);
    wait_quiet();

    // zero center and limits: wrapped moves, zero threshold
    write_reg(jtkm_pkg::CFG_CENTER, 10'd0);
    write_reg(jtkm_pkg::CFG_DZ, 10'd0);
    write_reg(jtkm_pkg::CFG_TH, 10'd0);
    send_sample(10'd1023, 10'd768, 1'b0);
    send_sample(10'd7,    10'd0,   1'b0);
    send_sample(10'd1,    10'd0,   1'b1);
    send_sample(10'd0,    10'd1,   1'b1);
    send_sample(10'd0,    10'd0,   1'b0);
    wait_quiet();

    // top center: truncation toward zero on negative offsets
    write_reg(jtkm_pkg::CFG_CENTER, 10'd1023);
    send_sample(10'd1016, 10'd1023, 1'b0);
    send_sample(10'd0,    10'd0,    1'b0);
    wait_quiet();

    // widest deadzone and threshold
    write_reg(jtkm_pkg::CFG_DZ, 10'd511);
    write_reg(jtkm_pkg::CFG_TH, 10'd511);
    send_sample(10'd0,   10'd1023, 1'b1);
    send_sample(10'd512, 10'd1023, 1'b0);
    send_sample(10'd512, 10'd512,  1'b1);
    wait_quiet();

    // default settings, long receiver hold, mid-phase pause
    write_reg(jtkm_pkg::CFG_CENTER, 10'd512);
    write_reg(jtkm_pkg::CFG_DZ, 10'd50);
    write_reg(jtkm_pkg::CFG_TH, 10'd200);
    run_random(10);
    hold_left = 80;
    run_random(12);
    wait_quiet();
    run_random(13);
    wait_quiet();

    // random settings with no idling on either side
    jitter_on = 1'b0;
    d = $urandom_range(10, 120);
    write_reg(jtkm_pkg::CFG_CENTER, 10'($urandom_range(256, 767)));
    write_reg(jtkm_pkg::CFG_DZ, 10'(d));
    write_reg(jtkm_pkg::CFG_TH, 10'($urandom_range(d, 300)));
    run_random(30);
    wait_quiet();

    // bottom center, oversize write masked, spare index ignored
    jitter_on = 1'b1;
    write_reg(jtkm_pkg::CFG_CENTER, 10'd0);
    write_reg(jtkm_pkg::CFG_DZ, 10'h3ff);
    write_reg(jtkm_pkg::CFG_TH, 10'd0);
    write_reg(CFG_SPARE, 10'($urandom_range(1023)));
    run_random(20);
    wait_quiet();

    // fully random settings
    write_reg(jtkm_pkg::CFG_CENTER, 10'($urandom_range(1023)));
    write_reg(jtkm_pkg::CFG_DZ, 10'($urandom_range(1023)));
    write_reg(jtkm_pkg::CFG_TH, 10'($urandom_range(1023)));
    run_random(23);
    wait_quiet();

    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
